// ----- src/adsr_pkg.sv -----
package adsr_pkg;

  // Width of every control field and of the level output
  localparam int FIELD_W = 16;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  // Command carried in tuser
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2
  } cmd_e;

  // Envelope stage as reported on the output
  typedef enum logic [2:0] {
    STAGE_IDLE    = 3'd0,
    STAGE_ATTACK  = 3'd1,
    STAGE_DECAY   = 3'd2,
    STAGE_SUSTAIN = 3'd3,
    STAGE_RELEASE = 3'd4
  } stage_e;

  // One input word after unpacking
  typedef struct packed {
    cmd_e               command;
    logic [FIELD_W-1:0] attack_step;
    logic [FIELD_W-1:0] decay_factor;
    logic [FIELD_W-1:0] sustain_level;
    logic [FIELD_W-1:0] release_factor;
  } item_t;

endpackage

// ----- src/adsr_in_stage.sv -----
module adsr_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  adsr_pkg::item_t s_item_i,
  input  logic            take_i,
  output logic            valid_o,
  output adsr_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  adsr_pkg::item_t item_q;
  logic            load;

  // Register frees up in the same cycle the core consumes it
  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- src/adsr_core.sv -----
module adsr_core #(
  parameter int LEVEL_BITS     = 16,
  parameter int SNAP_THRESHOLD = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  adsr_pkg::item_t              item_i,
  output logic                         take_o,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic [adsr_pkg::FIELD_W-1:0] level_o,
  output adsr_pkg::stage_e             stage_o
);

  localparam int FW = adsr_pkg::FIELD_W;
  // Level register must also hold any sustain value
  localparam int LW = (LEVEL_BITS > FW) ? LEVEL_BITS : FW;
  localparam int PW = LW + FW;
  localparam logic [LW-1:0] LevelMax = LW'((64'd1 << LEVEL_BITS) - 64'd1);
  localparam logic [LW:0]   SnapThr  = (LW+1)'(SNAP_THRESHOLD);

  adsr_pkg::stage_e stage_q, stage_d;
  logic [LW-1:0]    level_q, level_d;
  logic [FW-1:0]    atk_q, atk_d;
  logic [FW-1:0]    dec_q, dec_d;
  logic [FW-1:0]    sus_q, sus_d;
  logic [FW-1:0]    rel_q, rel_d;

  logic                  out_valid_q, out_valid_d;
  logic [FW-1:0]         out_level_q;
  adsr_pkg::stage_e      out_stage_q;

  logic          fire;
  logic [LW-1:0] sus_ext;
  logic [LW-1:0] gap;
  logic          above;
  logic [LW-1:0] mul_a;
  logic [FW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [LW-1:0] step;
  logic [LW:0]   sum;
  logic [LW-1:0] decayed;
  logic [LW:0]   snap_lim;

  // Process the held word when the result register can take it
  assign fire   = valid_i && (!out_valid_q || m_ready_i);
  assign take_o = fire;

  // Shared multiplier: gap to sustain in decay, level in release
  assign sus_ext  = LW'(sus_q);
  assign gap      = level_q - sus_ext;
  assign above    = level_q > sus_ext;
  assign mul_a    = (stage_q == adsr_pkg::STAGE_DECAY) ? gap : level_q;
  assign mul_b    = (stage_q == adsr_pkg::STAGE_DECAY) ? dec_q : rel_q;
  assign prod     = PW'(mul_a) * PW'(mul_b);
  assign step     = prod[PW-1:FW];

  assign sum      = (LW+1)'(level_q) + (LW+1)'(atk_q);
  assign decayed  = above ? (level_q - step) : level_q;
  assign snap_lim = (LW+1)'(sus_q) + SnapThr;

  // Next envelope state
  always_comb begin
    stage_d = stage_q;
    level_d = level_q;
    atk_d   = atk_q;
    dec_d   = dec_q;
    sus_d   = sus_q;
    rel_d   = rel_q;
    if (fire) begin
      case (item_i.command)
        adsr_pkg::CMD_TICK: begin
          case (stage_q)
            adsr_pkg::STAGE_ATTACK: begin
              if (sum >= {1'b0, LevelMax}) begin
                level_d = LevelMax;
                stage_d = adsr_pkg::STAGE_DECAY;
              end else begin
                level_d = sum[LW-1:0];
              end
            end
            adsr_pkg::STAGE_DECAY: begin
              if (dec_q == adsr_pkg::FIELD_MAX) begin
                level_d = sus_ext;
                stage_d = adsr_pkg::STAGE_SUSTAIN;
              end else if ((LW+1)'(decayed) <= snap_lim) begin
                level_d = sus_ext;
                stage_d = adsr_pkg::STAGE_SUSTAIN;
              end else begin
                level_d = decayed;
              end
            end
            adsr_pkg::STAGE_SUSTAIN: begin
              level_d = sus_ext;
            end
            adsr_pkg::STAGE_RELEASE: begin
              if (rel_q == '0 || (LW+1)'(step) < SnapThr) begin
                level_d = '0;
                stage_d = adsr_pkg::STAGE_IDLE;
              end else begin
                level_d = step;
              end
            end
            default: begin
              level_d = '0;
              stage_d = adsr_pkg::STAGE_IDLE;
            end
          endcase
        end
        adsr_pkg::CMD_NOTE_ON: begin
          atk_d   = item_i.attack_step;
          dec_d   = item_i.decay_factor;
          sus_d   = item_i.sustain_level;
          rel_d   = item_i.release_factor;
          level_d = '0;
          stage_d = adsr_pkg::STAGE_ATTACK;
        end
        adsr_pkg::CMD_NOTE_OFF: begin
          if (stage_q == adsr_pkg::STAGE_ATTACK || stage_q == adsr_pkg::STAGE_DECAY ||
              stage_q == adsr_pkg::STAGE_SUSTAIN) begin
            stage_d = adsr_pkg::STAGE_RELEASE;
          end
        end
        default: begin
          // unused command code: state unchanged
        end
      endcase
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= adsr_pkg::STAGE_IDLE;
      level_q     <= '0;
      atk_q       <= '0;
      dec_q       <= '0;
      sus_q       <= '0;
      rel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stage_q     <= stage_d;
      level_q     <= level_d;
      atk_q       <= atk_d;
      dec_q       <= dec_d;
      sus_q       <= sus_d;
      rel_q       <= rel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_level_q <= level_d[FW-1:0];
      out_stage_q <= stage_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign level_o   = out_level_q;
  assign stage_o   = out_stage_q;

  // Idle always means a silent envelope
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q == adsr_pkg::STAGE_IDLE |-> level_q == '0)
    else $error("level not zero in idle");

  // Sustain tracks the held sustain level
  a_sustain_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q == adsr_pkg::STAGE_SUSTAIN |-> level_q == sus_ext)
    else $error("sustain level mismatch");

  // Attack never overshoots full scale
  a_attack_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q == adsr_pkg::STAGE_ATTACK |-> level_q <= LevelMax)
    else $error("attack level above full scale");

  // Note on restarts attack from zero
  a_note_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_i.command == adsr_pkg::CMD_NOTE_ON |=>
      stage_q == adsr_pkg::STAGE_ATTACK && level_q == '0)
    else $error("note on did not retrigger");

  // Result word reflects the state just written
  a_result_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q && out_level_q == level_q[FW-1:0] && out_stage_q == stage_q)
    else $error("result word does not match state");

endmodule

// ----- src/adsr_envelope_generator.sv -----
// ADSR envelope generator. Each input word is a command in tuser: tick
// advances the envelope by one sample, note on latches the attack step,
// decay factor, sustain level and release factor from tdata, clears the
// level and starts attack, note off moves attack, decay or sustain to
// release. Attack is linear to full scale, decay closes a fraction of the
// gap to sustain per tick and snaps when within SNAP_THRESHOLD, release
// multiplies the level down and drops to idle below SNAP_THRESHOLD. Every
// word returns exactly one result word holding level and stage. Throughput
// is one word per clock while the receiver keeps up; the input register
// holds each accepted word, and the core then runs one multiply, add and
// compare into the state and result registers once the result register
// can take it. Both sides may stall freely.
module adsr_envelope_generator #(
  parameter int LEVEL_BITS     = 16,
  parameter int SNAP_THRESHOLD = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // attack_step, decay_factor, sustain_level, release_factor
  input  logic [1:0]  s_axis_tuser,  // command
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // level[15:0], stage[18:16], zero pad
);

  localparam int FW = adsr_pkg::FIELD_W;

  adsr_pkg::item_t  s_item;
  adsr_pkg::item_t  core_item;
  logic             core_valid;
  logic             core_take;
  logic [FW-1:0]    level;
  adsr_pkg::stage_e stage;

  // Unpack input word
  assign s_item.command        = adsr_pkg::cmd_e'(s_axis_tuser);
  assign s_item.attack_step    = s_axis_tdata[FW-1:0];
  assign s_item.decay_factor   = s_axis_tdata[2*FW-1:FW];
  assign s_item.sustain_level  = s_axis_tdata[3*FW-1:2*FW];
  assign s_item.release_factor = s_axis_tdata[4*FW-1:3*FW];

  adsr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .take_i    (core_take),
    .valid_o   (core_valid),
    .item_o    (core_item)
  );

  adsr_core #(
    .LEVEL_BITS     (LEVEL_BITS),
    .SNAP_THRESHOLD (SNAP_THRESHOLD)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (core_valid),
    .item_i    (core_item),
    .take_o    (core_take),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .level_o   (level),
    .stage_o   (stage)
  );

  // Pack result word
  assign m_axis_tdata = {5'd0, stage, level};

endmodule

// ----- tb/adsr_envelope_generator_tb.sv -----
module adsr_envelope_generator_tb;
  import adsr_pkg::*;

  localparam int            SNAP         = 7;
  localparam logic [31:0]   FULL_SCALE   = 32'h0000_FFFF;
  localparam logic [1:0]    CMD_UNUSED   = 2'd3;  // no enum member; block must ignore it
  localparam int            RANDOM_WORDS = 1400;
  localparam int            CALM_TAIL    = 150;   // last words run with no idling
  localparam int            LONG_HOLD    = 400;   // receiver hold-off, in cycles
  localparam int            HOLD_AFTER   = 300;   // results seen before the hold-off
  localparam int            DRAIN_CYCLES = 10;
  localparam int            DIR_N        = 24;

  typedef struct packed {
    logic [15:0] level;
    stage_e      stage;
  } env_out_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] atk;
    logic [15:0] dec;
    logic [15:0] sus;
    logic [15:0] rel;
    logic        typed;
    logic [15:0] lvl;
    stage_e      stg;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  // Predictor state
  stage_e      env_stage;
  logic [31:0] env_level;
  logic [15:0] hold_attack;
  logic [15:0] hold_decay;
  logic [15:0] hold_sustain;
  logic [15:0] hold_release;

  env_out_t    expected_env[$];
  int          words_sent;
  int          words_checked;
  int          errors;
  int          note_ons;
  int          note_offs;
  int          unused_cmds;
  int          stage_hits[5];
  bit          calm;

  // Directed words: extremes, every command, retrigger and the corner rules
  dir_row_t directed_rows [DIR_N] = '{
    '{CMD_TICK,     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, STAGE_IDLE},
    '{CMD_NOTE_OFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, STAGE_IDLE},
    '{CMD_UNUSED,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, STAGE_IDLE},
    // instant attack and decay, instant release
    '{CMD_NOTE_ON,  16'hFFFF, 16'hFFFF, 16'h8000, 16'h0000, 1'b1, 16'h0000, STAGE_ATTACK},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF, STAGE_DECAY},
    '{CMD_TICK,     16'h5A5A, 16'hA5A5, 16'h5A5A, 16'hA5A5, 1'b1, 16'h8000, STAGE_SUSTAIN},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h8000, STAGE_SUSTAIN},
    '{CMD_NOTE_OFF, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b1, 16'h8000, STAGE_RELEASE},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, STAGE_IDLE},
    // zero attack step holds attack until note off
    '{CMD_NOTE_ON,  16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, STAGE_ATTACK},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAGE_IDLE},
    '{CMD_NOTE_OFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, STAGE_RELEASE},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAGE_IDLE},
    // sustain at full scale: decay snaps straight to sustain
    '{CMD_NOTE_ON,  16'h4000, 16'h8000, 16'hFFFF, 16'h8000, 1'b0, 16'h0000, STAGE_IDLE},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAGE_IDLE},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAGE_IDLE},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAGE_IDLE},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAGE_IDLE},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAGE_IDLE},
    // retrigger during sustain, zero decay factor, slowest release
    '{CMD_NOTE_ON,  16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, STAGE_ATTACK},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF, STAGE_DECAY},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAGE_IDLE},
    '{CMD_NOTE_OFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF, STAGE_RELEASE},
    '{CMD_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAGE_IDLE}
  };

  adsr_envelope_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Envelope update for one accepted word
  function automatic void advance_envelope(input logic [1:0] cmd, input logic [63:0] ctl);
    logic [47:0] prod;
    prod = '0;
    case (cmd)
      CMD_TICK: begin
        case (env_stage)
          STAGE_ATTACK: begin
            env_level = env_level + hold_attack;
            if (env_level >= FULL_SCALE) begin
              env_level = FULL_SCALE;
              env_stage = STAGE_DECAY;
            end
          end
          STAGE_DECAY: begin
            if (hold_decay == FIELD_MAX) begin
              env_level = hold_sustain;
              env_stage = STAGE_SUSTAIN;
            end else begin
              if (env_level > hold_sustain) begin
                prod = (env_level - hold_sustain) * hold_decay;
                env_level = env_level - prod[47:16];
              end
              // close enough to sustain: snap
              if (env_level <= hold_sustain + SNAP) begin
                env_level = hold_sustain;
                env_stage = STAGE_SUSTAIN;
              end
            end
          end
          STAGE_SUSTAIN: env_level = hold_sustain;
          STAGE_RELEASE: begin
            if (hold_release == '0) begin
              env_level = '0;
              env_stage = STAGE_IDLE;
            end else begin
              prod = env_level * hold_release;
              env_level = prod[47:16];
              if (env_level < SNAP) begin
                env_level = '0;
                env_stage = STAGE_IDLE;
              end
            end
          end
          default: begin
            env_level = '0;
            env_stage = STAGE_IDLE;
          end
        endcase
      end
      CMD_NOTE_ON: begin
        hold_attack  = ctl[15:0];
        hold_decay   = ctl[31:16];
        hold_sustain = ctl[47:32];
        hold_release = ctl[63:48];
        env_level    = '0;
        env_stage    = STAGE_ATTACK;
      end
      CMD_NOTE_OFF: begin
        if (env_stage inside {STAGE_ATTACK, STAGE_DECAY, STAGE_SUSTAIN})
          env_stage = STAGE_RELEASE;
      end
      default: ;
    endcase
  endfunction

  // Biased control value: extremes now and then, otherwise lo..full scale
  function automatic logic [15:0] pick_control(input int lo);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(lo, 16'hFFFF));
  endfunction

  task automatic note_error(input string what, input env_out_t want, input env_out_t got);
    errors++;
    if (errors <= 10)
      $display("mismatch #%0d (%s): expected level %h stage %0d, got level %h stage %0d",
               errors, what, want.level, want.stage, got.level, got.stage);
  endtask

  // Offer one word, wait for the handshake, then record its expected result
  task automatic send_word(input logic [1:0] cmd, input logic [63:0] data,
                           input bit typed = 1'b0, input env_out_t typed_out = '0);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 14);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_envelope(cmd, data);
    if (typed) expected_env.push_back(typed_out);
    else expected_env.push_back('{level: env_level[15:0], stage: env_stage});
    words_sent++;
    case (cmd)
      CMD_NOTE_ON:  note_ons++;
      CMD_NOTE_OFF: note_offs++;
      CMD_UNUSED:   unused_cmds++;
      default: ;
    endcase
  endtask

  task automatic send_junk_tick();
    send_word(CMD_TICK, {$urandom, $urandom});
  endtask

  // Result checker
  always @(posedge clk_i) begin
    env_out_t want;
    env_out_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.level = m_axis_tdata[15:0];
      got.stage = stage_e'(m_axis_tdata[18:16]);
      if (expected_env.size() == 0) begin
        note_error("no result pending", '0, got);
      end else begin
        want = expected_env.pop_front();
        words_checked++;
        if (got.level !== want.level) note_error("level", want, got);
        if (got.stage !== want.stage) note_error("stage", want, got);
        if (want.stage <= STAGE_RELEASE) stage_hits[want.stage]++;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    int hold;
    bit held_long;
    hold = 0;
    held_long = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_long && words_checked >= HOLD_AFTER) begin
        held_long = 1'b1;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        hold = $urandom_range(1, 14) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    dir_row_t row;
    env_out_t typed_out;
    env_stage     = STAGE_IDLE;
    env_level     = '0;
    hold_attack   = '0;
    hold_decay    = '0;
    hold_sustain  = '0;
    hold_release  = '0;
    words_sent    = 0;
    words_checked = 0;
    errors        = 0;
    note_ons      = 0;
    note_offs     = 0;
    unused_cmds   = 0;
    calm          = 1'b0;
    foreach (stage_hits[i]) stage_hits[i] = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      row = directed_rows[i];
      typed_out.level = row.lvl;
      typed_out.stage = row.stg;
      send_word(row.cmd, {row.rel, row.sus, row.dec, row.atk}, row.typed, typed_out);
    end

    // random notes: mostly well-formed note on / ticks / note off runs
    while (words_sent < DIR_N + RANDOM_WORDS) begin
      if (words_sent >= DIR_N + RANDOM_WORDS - CALM_TAIL) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        send_word(2'($urandom_range(0, 3)), {$urandom, $urandom});
      end else begin
        send_word(CMD_NOTE_ON, {pick_control(16'h4000), 16'($urandom),
                                pick_control(16'h0800), pick_control(16'd1500)});
        repeat ($urandom_range(0, 50)) send_junk_tick();
        if ($urandom_range(0, 4) != 0) send_word(CMD_NOTE_OFF, {$urandom, $urandom});
        repeat ($urandom_range(0, 60)) send_junk_tick();
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (expected_env.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d words (%0d note on, %0d note off, %0d unused code); %0d results checked",
             words_sent, note_ons, note_offs, unused_cmds, words_checked);
    $display("Results per stage: idle %0d, attack %0d, decay %0d, sustain %0d, release %0d",
             stage_hits[0], stage_hits[1], stage_hits[2], stage_hits[3], stage_hits[4]);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", expected_env.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
